>>> sv/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg: shared types for the service and method registry
// Request and response records, opcodes and the command record passed from
// the front end to the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

  // Default table sizes.
  localparam int unsigned SERVICE_SLOTS_DEF = 16;
  localparam int unsigned METHOD_SLOTS_DEF  = 16;

  // Opcodes as they arrive on the request channel.
  typedef enum logic [2:0] {
    OP_ADD_SVC  = 3'd0,
    OP_DEL_SVC  = 3'd1,
    OP_ADD_MTH  = 3'd2,
    OP_DEL_MTH  = 3'd3,
    OP_FIND_SVC = 3'd4,
    OP_FIND_MTH = 3'd5
  } op_e;

  // Command class decided by the front end.
  typedef enum logic [2:0] {
    CL_ADD_SVC  = 3'd0,
    CL_DEL_SVC  = 3'd1,
    CL_ADD_MTH  = 3'd2,
    CL_DEL_MTH  = 3'd3,
    CL_FIND_SVC = 3'd4,
    CL_FIND_MTH = 3'd5,
    CL_NONE     = 3'd7
  } cls_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] service_key;
    logic [15:0] instance_key;
    logic [15:0] port;
    logic [15:0] if_version;
    logic [15:0] method_key;
    logic [7:0]  handler_tag;
    logic [3:0]  service_slot;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] found_service_slot;
    logic [3:0] found_method_slot;
    logic [7:0] found_handler;
  } rsp_t;

  // Classified request handed to the engine.
  typedef struct packed {
    req_t req;
    cls_e cls;
    logic by_inst;
  } cmd_t;

  // One method table entry.
  typedef struct packed {
    logic        vld;
    logic [15:0] id;
    logic [7:0]  hnd;
  } mth_t;

endpackage

`default_nettype wire

>>> sv/smr_front.sv
// ----------------------------------------------------------------------------
// smr_front: request intake and classification
// Decodes each request into a command class and holds it in a two-entry
// queue so that intake and execution stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_front
  import smr_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic cmd_valid_o,
  input  wire  cmd_ready_i,
  output cmd_t cmd_o
);

  cmd_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push, pop;

  // Decode the opcode into a command class.
  always_comb begin
    dec.req     = in_req_i;
    dec.by_inst = 1'b0;
    unique case (in_req_i.opcode)
      OP_ADD_SVC:  begin dec.cls = CL_ADD_SVC; dec.by_inst = 1'b1; end
      OP_DEL_SVC:  begin dec.cls = CL_DEL_SVC; dec.by_inst = 1'b1; end
      OP_ADD_MTH:  dec.cls = CL_ADD_MTH;
      OP_DEL_MTH:  dec.cls = CL_DEL_MTH;
      OP_FIND_SVC: dec.cls = CL_FIND_SVC;
      OP_FIND_MTH: dec.cls = CL_FIND_MTH;
      default:     dec.cls = CL_NONE;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= dec;
  end

endmodule

`default_nettype wire

>>> sv/smr_engine.sv
// ----------------------------------------------------------------------------
// smr_engine: registry execution engine
// Scans the service table, one method table or both, one entry per cycle,
// applies the update and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_engine
  import smr_pkg::*;
#(
  parameter int unsigned SERVICE_SLOTS = SERVICE_SLOTS_DEF,
  parameter int unsigned METHOD_SLOTS  = METHOD_SLOTS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned NMAX = (SERVICE_SLOTS > METHOD_SLOTS) ? SERVICE_SLOTS : METHOD_SLOTS;
  localparam int unsigned SW = (SERVICE_SLOTS > 1) ? $clog2(SERVICE_SLOTS) : 1;
  localparam int unsigned MW = (METHOD_SLOTS > 1) ? $clog2(METHOD_SLOTS) : 1;
  localparam int unsigned AW = (SERVICE_SLOTS * METHOD_SLOTS > 1) ?
                               $clog2(SERVICE_SLOTS * METHOD_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NMAX + 1);
  localparam int unsigned NW = $clog2(METHOD_SLOTS + 1);
  localparam int unsigned TW = $clog2(SERVICE_SLOTS + 1);
  localparam int unsigned DEPTH = SERVICE_SLOTS * METHOD_SLOTS;

  localparam logic [CW-1:0] SS_C  = CW'(SERVICE_SLOTS);
  localparam logic [CW-1:0] MS_C  = CW'(METHOD_SLOTS);
  localparam logic [CW-1:0] MS_L  = CW'(METHOD_SLOTS - 1);
  localparam logic [AW-1:0] MS_A  = AW'(METHOD_SLOTS);
  localparam logic [NW-1:0] MS_N  = NW'(METHOD_SLOTS);
  localparam logic [TW-1:0] SS_T  = TW'(SERVICE_SLOTS);

  typedef struct packed {
    logic [15:0]   sid;
    logic [15:0]   inst;
    logic [15:0]   prt;
    logic [15:0]   ver;
    logic [NW-1:0] cnt;
  } srec_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SSCAN = 5'b00010,
    S_MSCAN = 5'b00100,
    S_MCLR  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Table storage.
  srec_t srec_mem [SERVICE_SLOTS];
  mth_t  mth_mem  [DEPTH];

  state_e             state_q, state_d;
  logic [CW-1:0]      idx_q, idx_d, cmp_idx_q, cmp_idx_d, free_idx_q, free_idx_d;
  logic               cmp_vld_q, cmp_vld_d, free_fnd_q, free_fnd_d;
  logic [SW-1:0]      slot_q, slot_d;
  srec_t              rec_q, rec_d;
  cmd_t               cmd_q, cmd_d;
  logic               ok_q, ok_d;
  logic [MW-1:0]      mslot_q, mslot_d;
  logic [7:0]         hnd_q, hnd_d;
  logic [SERVICE_SLOTS-1:0] svalid_q, svalid_d;
  logic [TW-1:0]      total_q, total_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic               srec_we;
  logic [SW-1:0]      srec_wa, srd_addr;
  srec_t              srec_wd, srec_rd_q;
  logic               mth_we;
  logic [AW-1:0]      mth_wa, mrd_addr, mth_base;
  mth_t               mth_wd, mth_rd_q;

  logic [SW-1:0]      s_ci, q_slot;
  logic [MW-1:0]      m_ci;
  logic               s_hit, m_hit, q_ok, s_key;

  // Compare paths for the entry read in the previous cycle.
  assign s_ci     = cmp_idx_q[SW-1:0];
  assign m_ci     = cmp_idx_q[MW-1:0];
  assign q_slot   = SW'(cmd_i.req.service_slot);
  assign q_ok     = (32'(cmd_i.req.service_slot) < SERVICE_SLOTS) && svalid_q[q_slot];
  assign mth_base = AW'(slot_q) * MS_A;
  assign s_key    = (srec_rd_q.sid == cmd_q.req.service_key) &&
                    (srec_rd_q.ver == cmd_q.req.if_version) &&
                    (cmd_q.by_inst ? (srec_rd_q.inst == cmd_q.req.instance_key)
                                   : (srec_rd_q.prt == cmd_q.req.port));
  assign s_hit    = cmp_vld_q && svalid_q[s_ci] && s_key;
  assign m_hit    = cmp_vld_q && mth_rd_q.vld && (mth_rd_q.id == cmd_q.req.method_key);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Sequencer.
  always_comb begin
    srec_t rec_upd;
    rec_upd     = rec_q;
    state_d     = state_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;
    slot_d      = slot_q;
    rec_d       = rec_q;
    cmd_d       = cmd_q;
    ok_d        = ok_q;
    mslot_d     = mslot_q;
    hnd_d       = hnd_q;
    svalid_d    = svalid_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    srec_we     = 1'b0;
    srec_wa     = slot_q;
    srec_wd     = rec_q;
    mth_we      = 1'b0;
    mth_wa      = mth_base + AW'(m_ci);
    mth_wd      = '0;
    srd_addr    = idx_q[SW-1:0];
    mrd_addr    = mth_base + AW'(idx_q[MW-1:0]);
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d      = cmd_i;
          ok_d       = 1'b0;
          mslot_d    = '0;
          hnd_d      = '0;
          slot_d     = '0;
          idx_d      = '0;
          free_fnd_d = 1'b0;
          state_d    = S_SSCAN;
          case (cmd_i.cls)
            CL_ADD_SVC: if (total_q >= SS_T) state_d = S_DONE;
            CL_DEL_SVC: if (total_q == '0) state_d = S_DONE;
            CL_FIND_MTH: begin
              if (q_ok) begin
                slot_d  = q_slot;
                state_d = S_MSCAN;
              end else begin
                state_d = S_DONE;
              end
            end
            CL_NONE: state_d = S_DONE;
            default: ;
          endcase
        end
      end

      S_SSCAN: begin
        if (idx_q < SS_C) begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
        end
        if (cmp_vld_q && !svalid_q[s_ci] && !free_fnd_q) begin
          free_fnd_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
        if (s_hit) begin
          slot_d     = s_ci;
          rec_d      = srec_rd_q;
          cmp_vld_d  = 1'b0;
          idx_d      = '0;
          free_fnd_d = 1'b0;
          state_d    = S_DONE;
          case (cmd_q.cls) inside
            CL_ADD_SVC, CL_FIND_SVC: ok_d = 1'b1;
            CL_DEL_SVC: begin
              svalid_d[s_ci] = 1'b0;
              total_d        = total_q - 1'b1;
              ok_d           = 1'b1;
            end
            CL_ADD_MTH: if (srec_rd_q.cnt < MS_N) state_d = S_MSCAN;
            CL_DEL_MTH: if (srec_rd_q.cnt != '0) state_d = S_MSCAN;
            default: ;
          endcase
        end else if (!cmp_vld_q && idx_q == SS_C) begin
          state_d = S_DONE;
          if (cmd_q.cls == CL_ADD_SVC && free_fnd_q) begin
            srec_we      = 1'b1;
            srec_wa      = free_idx_q[SW-1:0];
            srec_wd.sid  = cmd_q.req.service_key;
            srec_wd.inst = cmd_q.req.instance_key;
            srec_wd.prt  = cmd_q.req.port;
            srec_wd.ver  = cmd_q.req.if_version;
            srec_wd.cnt  = '0;
            svalid_d[free_idx_q[SW-1:0]] = 1'b1;
            total_d = total_q + 1'b1;
            slot_d  = free_idx_q[SW-1:0];
            ok_d    = 1'b1;
            idx_d   = '0;
            state_d = S_MCLR;
          end
        end
      end

      S_MSCAN: begin
        if (idx_q < MS_C) begin
          idx_d     = idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
        end
        if (cmp_vld_q && !mth_rd_q.vld && !free_fnd_q) begin
          free_fnd_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
        if (m_hit) begin
          cmp_vld_d = 1'b0;
          state_d   = S_DONE;
          ok_d      = 1'b1;
          mslot_d   = m_ci;
          if (cmd_q.cls == CL_FIND_MTH) hnd_d = mth_rd_q.hnd;
          if (cmd_q.cls == CL_DEL_MTH) begin
            mth_we      = 1'b1;
            rec_upd.cnt = rec_q.cnt - 1'b1;
            srec_we     = 1'b1;
            srec_wd     = rec_upd;
          end
        end else if (!cmp_vld_q && idx_q == MS_C) begin
          state_d = S_DONE;
          if (cmd_q.cls == CL_ADD_MTH && free_fnd_q) begin
            mth_we      = 1'b1;
            mth_wa      = mth_base + AW'(free_idx_q[MW-1:0]);
            mth_wd.vld  = 1'b1;
            mth_wd.id   = cmd_q.req.method_key;
            mth_wd.hnd  = cmd_q.req.handler_tag;
            rec_upd.cnt = rec_q.cnt + 1'b1;
            srec_we     = 1'b1;
            srec_wd     = rec_upd;
            ok_d        = 1'b1;
            mslot_d     = free_idx_q[MW-1:0];
          end
        end
      end

      S_MCLR: begin
        // Empty the method table of a newly allocated service.
        mth_we = 1'b1;
        mth_wa = mth_base + AW'(idx_q[MW-1:0]);
        idx_d  = idx_q + 1'b1;
        if (idx_q == MS_L) state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d              = 1'b1;
          out_d.ok                 = ok_q;
          out_d.found_service_slot = ok_q ? 4'(slot_q) : 4'd0;
          out_d.found_method_slot  = ok_q ? 4'(mslot_q) : 4'd0;
          out_d.found_handler      = ok_q ? hnd_q : 8'd0;
          state_d                  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      svalid_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      free_fnd_q  <= free_fnd_d;
      svalid_q    <= svalid_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    slot_q     <= slot_d;
    rec_q      <= rec_d;
    cmd_q      <= cmd_d;
    ok_q       <= ok_d;
    mslot_q    <= mslot_d;
    hnd_q      <= hnd_d;
    out_q      <= out_d;
  end

  // Service table memory.
  always_ff @(posedge clk_i) begin
    if (srec_we) srec_mem[srec_wa] <= srec_wd;
    srec_rd_q <= srec_mem[srd_addr];
  end

  // Method table memory.
  always_ff @(posedge clk_i) begin
    if (mth_we) mth_mem[mth_wa] <= mth_wd;
    mth_rd_q <= mth_mem[mrd_addr];
  end

endmodule

`default_nettype wire

>>> sv/service_method_registry.sv
// Response time depends on the request: requests refused up front or with an
// unknown opcode skip the table scans, others wait for the one-entry-per-cycle
// table scans and, on a new service, the method-table clear. The engine works
// on one request at a time while a two-entry queue keeps taking requests.
// Reset: asynchronous, clears service valid bits, service count and handshakes.
// ----------------------------------------------------------------------------
// service_method_registry: two-level service and method registry
// A front end takes and classifies requests; an engine scans the tables,
// applies updates and returns one response per request.
// ----------------------------------------------------------------------------
`default_nettype none

module service_method_registry
  import smr_pkg::*;
#(
  parameter int unsigned SERVICE_SLOTS = SERVICE_SLOTS_DEF,
  parameter int unsigned METHOD_SLOTS  = METHOD_SLOTS_DEF
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output rsp_t out_rsp_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Request intake.
  smr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Table engine.
  smr_engine #(
    .SERVICE_SLOTS (SERVICE_SLOTS),
    .METHOD_SLOTS  (METHOD_SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> sv/smr_checker.sv
// ----------------------------------------------------------------------------
// smr_checker: port-level checks for the registry
// Watches the request and response channels and tracks outstanding requests.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_checker
  import smr_pkg::*;
(
  input wire  clk_i,
  input wire  rst_ni,
  input wire  in_valid_i,
  input wire  in_ready_o,
  input wire  out_valid_o,
  input wire  out_ready_i,
  input rsp_t out_rsp_o
);

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Requests taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  // A stalled response holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // A failed request reports nothing else.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.ok |-> out_rsp_o.found_service_slot == 4'd0 &&
      out_rsp_o.found_method_slot == 4'd0 && out_rsp_o.found_handler == 8'd0)
    else $error("failed response carries data");

  // Every response answers a request.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("response without request");

  // Queue, engine and output register bound the requests in flight.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many requests in flight");

endmodule

bind service_method_registry smr_checker u_smr_checker (.*);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the service and method registry
// A queue-fed driver offers requests under changing idle and stall rates. A
// predictor keeps its own copy of the tables and works out each response, and
// a monitor compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import smr_pkg::*;

  localparam int unsigned NSVC = SERVICE_SLOTS_DEF;
  localparam int unsigned NMTH = METHOD_SLOTS_DEF;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 255;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  service_method_registry i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted copy of the registry tables.
  logic        svc_vld  [NSVC];
  logic [15:0] svc_id   [NSVC];
  logic [15:0] svc_inst [NSVC];
  logic [15:0] svc_port [NSVC];
  logic [15:0] svc_ver  [NSVC];
  int unsigned mth_cnt  [NSVC];
  logic        mth_vld  [NSVC][NMTH];
  logic [15:0] mth_id   [NSVC][NMTH];
  logic [7:0]  mth_hnd  [NSVC][NMTH];
  int unsigned svc_used = 0;

  req_t pending_q[$];
  rsp_t predicted_q[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic hold_phase = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned mismatches = 0;

  // Key pools, so that lookups hit often.
  logic [15:0] pool_sid [24];
  logic [15:0] pool_inst[24];
  logic [15:0] pool_port[24];
  logic [15:0] pool_ver [24];
  logic [15:0] pool_mid [24];

  function automatic int find_by_inst(logic [15:0] sid, logic [15:0] inst, logic [15:0] ver);
    for (int s = 0; s < NSVC; s++) begin
      if (svc_vld[s] && svc_id[s] == sid && svc_inst[s] == inst && svc_ver[s] == ver) return s;
    end
    return -1;
  endfunction

  function automatic int find_by_port(logic [15:0] sid, logic [15:0] prt, logic [15:0] ver);
    for (int s = 0; s < NSVC; s++) begin
      if (svc_vld[s] && svc_id[s] == sid && svc_port[s] == prt && svc_ver[s] == ver) return s;
    end
    return -1;
  endfunction

  function automatic int find_method(int s, logic [15:0] mid);
    for (int m = 0; m < NMTH; m++) begin
      if (mth_vld[s][m] && mth_id[s][m] == mid) return m;
    end
    return -1;
  endfunction

  // Apply one request to the predicted tables and return its response.
  function automatic rsp_t registry_update(req_t r);
    rsp_t res;
    int s;
    int m;
    res = '0;
    case (r.opcode)
      OP_ADD_SVC: begin
        if (svc_used < NSVC) begin
          s = find_by_inst(r.service_key, r.instance_key, r.if_version);
          if (s >= 0) begin
            res.ok = 1'b1;
            res.found_service_slot = s[3:0];
          end else begin
            for (int i = 0; i < NSVC; i++) begin
              if (!svc_vld[i] && !res.ok) begin
                svc_vld[i] = 1'b1;
                svc_id[i] = r.service_key;
                svc_inst[i] = r.instance_key;
                svc_port[i] = r.port;
                svc_ver[i] = r.if_version;
                mth_cnt[i] = 0;
                for (int k = 0; k < NMTH; k++) begin
                  mth_vld[i][k] = 1'b0;
                  mth_id[i][k] = '0;
                  mth_hnd[i][k] = '0;
                end
                svc_used++;
                res.ok = 1'b1;
                res.found_service_slot = i[3:0];
              end
            end
          end
        end
      end
      OP_DEL_SVC: begin
        s = (svc_used == 0) ? -1 :
            find_by_inst(r.service_key, r.instance_key, r.if_version);
        if (s >= 0) begin
          svc_vld[s] = 1'b0;
          svc_id[s] = '0;
          svc_inst[s] = '0;
          svc_port[s] = '0;
          svc_ver[s] = '0;
          mth_cnt[s] = 0;
          for (int k = 0; k < NMTH; k++) begin
            mth_vld[s][k] = 1'b0;
            mth_id[s][k] = '0;
            mth_hnd[s][k] = '0;
          end
          svc_used--;
          res.ok = 1'b1;
          res.found_service_slot = s[3:0];
        end
      end
      OP_ADD_MTH: begin
        s = find_by_port(r.service_key, r.port, r.if_version);
        if (s >= 0 && mth_cnt[s] < NMTH) begin
          m = find_method(s, r.method_key);
          if (m >= 0) begin
            res.ok = 1'b1;
            res.found_service_slot = s[3:0];
            res.found_method_slot = m[3:0];
          end else begin
            for (int k = 0; k < NMTH; k++) begin
              if (!mth_vld[s][k] && !res.ok) begin
                mth_vld[s][k] = 1'b1;
                mth_id[s][k] = r.method_key;
                mth_hnd[s][k] = r.handler_tag;
                mth_cnt[s]++;
                res.ok = 1'b1;
                res.found_service_slot = s[3:0];
                res.found_method_slot = k[3:0];
              end
            end
          end
        end
      end
      OP_DEL_MTH: begin
        s = find_by_port(r.service_key, r.port, r.if_version);
        if (s >= 0 && mth_cnt[s] != 0) begin
          m = find_method(s, r.method_key);
          if (m >= 0) begin
            mth_vld[s][m] = 1'b0;
            mth_id[s][m] = '0;
            mth_hnd[s][m] = '0;
            mth_cnt[s]--;
            res.ok = 1'b1;
            res.found_service_slot = s[3:0];
            res.found_method_slot = m[3:0];
          end
        end
      end
      OP_FIND_SVC: begin
        s = find_by_port(r.service_key, r.port, r.if_version);
        if (s >= 0) begin
          res.ok = 1'b1;
          res.found_service_slot = s[3:0];
        end
      end
      OP_FIND_MTH: begin
        if (svc_vld[r.service_slot]) begin
          m = find_method(r.service_slot, r.method_key);
          if (m >= 0) begin
            res.ok = 1'b1;
            res.found_service_slot = r.service_slot;
            res.found_method_slot = m[3:0];
            res.found_handler = mth_hnd[r.service_slot][m];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random request: mostly from the key pools, some pure noise.
  function automatic req_t random_request();
    req_t r;
    int t;
    int w;
    r.opcode = 3'($urandom_range(7));
    r.service_key = 16'($urandom);
    r.instance_key = 16'($urandom);
    r.port = 16'($urandom);
    r.if_version = 16'($urandom);
    r.method_key = 16'($urandom);
    r.handler_tag = 8'($urandom);
    r.service_slot = 4'($urandom);
    if ($urandom_range(99) < 90) begin
      t = $urandom_range(23);
      r.service_key = pool_sid[t];
      r.instance_key = pool_inst[t];
      r.port = pool_port[t];
      r.if_version = pool_ver[t];
      r.method_key = pool_mid[$urandom_range(23)];
      w = $urandom_range(99);
      if (w < 24) r.opcode = OP_ADD_SVC;
      else if (w < 34) r.opcode = OP_DEL_SVC;
      else if (w < 60) r.opcode = OP_ADD_MTH;
      else if (w < 72) r.opcode = OP_DEL_MTH;
      else if (w < 84) r.opcode = OP_FIND_SVC;
      else r.opcode = OP_FIND_MTH;
    end
    return r;
  endfunction

  // Driver: offers queued requests and predicts each accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) predicted_q.push_back(registry_update(in_req));
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_req <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk_i) begin
    if (hold_phase && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  // Receiver ready with random stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= !(hold_phase && hold_cnt < HOLD_CYCLES - 1) &&
                   ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: compares each accepted response with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (predicted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_rsp);
      end else begin
        want = predicted_q.pop_front();
        if (out_rsp.ok !== want.ok ||
            out_rsp.found_service_slot !== want.found_service_slot ||
            out_rsp.found_method_slot !== want.found_method_slot ||
            out_rsp.found_handler !== want.found_handler) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_rsp);
        end
      end
    end
  end

  task automatic push_req(logic [2:0] op, logic [15:0] sid, logic [15:0] inst,
                          logic [15:0] prt, logic [15:0] ver, logic [15:0] mid,
                          logic [7:0] tag, logic [3:0] slot);
    req_t r;
    r = '{op, sid, inst, prt, ver, mid, tag, slot};
    pending_q.push_back(r);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || predicted_q.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus sequencing.
  initial begin
    for (int s = 0; s < NSVC; s++) svc_vld[s] = 1'b0;
    for (int i = 0; i < 24; i++) begin
      pool_sid[i] = (i < 2) ? 16'hFFFF : 16'($urandom_range(3));
      pool_inst[i] = (i == 0) ? 16'hFFFF : 16'($urandom_range(2));
      pool_port[i] = (i == 0) ? 16'hFFFF : 16'($urandom_range(2));
      pool_ver[i] = (i == 1) ? 16'hFFFF : 16'($urandom_range(1));
      pool_mid[i] = (i == 0) ? 16'hFFFF : 16'(i);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, duplicates, refusals, spare opcodes.
    push_req(OP_FIND_SVC, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_DEL_SVC, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_FIND_MTH, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_ADD_MTH, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_ADD_SVC, '1, '1, '1, '1, 0, 0, 0);
    push_req(OP_ADD_SVC, '1, '1, 16'h1, '1, 0, 0, 0);
    push_req(OP_ADD_SVC, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_FIND_SVC, '1, 0, '1, '1, 0, 0, 0);
    push_req(OP_DEL_MTH, '1, 0, '1, '1, '1, 0, 0);
    push_req(OP_ADD_MTH, '1, 0, '1, '1, '1, '1, 0);
    push_req(OP_ADD_MTH, '1, 0, '1, '1, '1, 8'h11, 0);
    push_req(OP_ADD_MTH, '1, 0, '1, '1, 0, 0, 0);
    push_req(OP_FIND_MTH, 0, 0, 0, 0, '1, 0, 0);
    push_req(OP_FIND_MTH, 0, 0, 0, 0, '1, 0, 1);
    push_req(OP_FIND_MTH, 0, 0, 0, 0, '1, 0, '1);
    push_req(OP_DEL_MTH, '1, 0, '1, '1, '1, 0, 0);
    push_req(OP_DEL_MTH, '1, 0, '1, '1, '1, 0, 0);
    push_req(OP_ADD_MTH, 0, 0, 16'h5, 0, 16'h5, 8'h5, 0);
    push_req(OP_SPARE_LO, '1, '1, '1, '1, '1, '1, '1);
    push_req(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_DEL_SVC, '1, '1, 0, '1, 0, 0, 0);
    push_req(OP_DEL_SVC, 0, 0, 0, 0, 0, 0, 0);
    push_req(OP_FIND_SVC, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases with different idle and stall rates.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 81; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 81; end
        3: begin tx_idle_pct = 24; rx_stall_pct = 24; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; hold_phase = 1'b1; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) pending_q.push_back(random_request());
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
